@@ sv/fvmp_pkg.sv @@
// Shared constants, types and tables of the four-thruster force mixer.
`default_nettype none

package fvmp_pkg;

	// Angle resolution kept from the 32-bit binary angle.
	localparam int ANG_W = 16;
	localparam logic [31:0] ANG_KEEP = 32'hFFFF_FFFF << (32 - ANG_W);

	// Rotation unit.
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
	localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
	localparam logic signed [32:0] HALF_TURN = 33'sh0_8000_0000;
	localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Fixed-point scale factors.
	localparam logic [29:0] HALF_SQRT2 = 30'd759250125;

	// Duty division and percent conversion.
	localparam int DIV_BITS = 31;
	localparam int PCT_BITS = 39;

	// Division by one hundred: after dropping two bits, multiply by the
	// reciprocal of twenty-five scaled by 2^42, split into a low and a high word.
	localparam logic [31:0] RECIP_LO = 32'hF5C2_8F5D;
	localparam logic [5:0]  RECIP_HI = 6'd40;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_MAX_FORCE  = 3'd0,
		REG_MIN_DUTY   = 3'd1,
		REG_MAX_DUTY   = 3'd2,
		REG_PWM_PERIOD = 3'd3
	} reg_idx_t;

	// State of one rotation step.
	typedef struct packed {
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [32:0] z;
		logic               flip;
		logic [15:0]        mag;
	} cordic_st_t;

	// Result of the rotation unit.
	typedef struct packed {
		logic               valid;
		logic signed [34:0] cos_v;
		logic signed [34:0] sin_v;
		logic [15:0]        mag;
	} cordic_out_t;

	// State of one divider lane: partial remainder and shifting dividend.
	typedef struct packed {
		logic [15:0]         rem;
		logic [DIV_BITS-1:0] work;
	} div_lane_t;

endpackage

`default_nettype wire

@@ sv/fvmp_if.sv @@
// Request channels of the force mixer: force command in, compare values out.
`default_nettype none

interface fvmp_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        force_magnitude;
	logic signed [15:0] force_angle;
	logic signed [15:0] heading;

	modport source (output valid, force_magnitude, force_angle, heading, input ready);
	modport sink (input valid, force_magnitude, force_angle, heading, output ready);
endinterface

interface fvmp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] compare_one;
	logic [31:0] compare_two;
	logic [31:0] compare_three;
	logic [31:0] compare_four;

	modport source (output valid, compare_one, compare_two, compare_three, compare_four,
		input ready);
	modport sink (input valid, compare_one, compare_two, compare_three, compare_four,
		output ready);
endinterface

`default_nettype wire

@@ sv/force_vector_to_motor_pwm.sv @@
// Top level of the four-thruster force mixer: rotation, mixing, duty and compare pipeline.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid / ready | force_magnitude, force_angle, heading
//   out_ch   | out | valid / ready | compare_one .. compare_four
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One request enters per cycle while out_ch does not stall; each result is offered after its
// request passes the 30 rotation stages, the 31-bit duty divider and ten single stages,
// the first of which loads at the accepting edge.
// arst_n clears every valid bit and loads the register defaults.
// A stall on out_ch freezes the whole pipeline in place, and in_ch.ready drops with it.
`default_nettype none

module force_vector_to_motor_pwm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	fvmp_in_if.sink          in_ch,
	fvmp_out_if.source       out_ch
);

	logic en;

	// Configuration registers.
	logic [15:0] max_force_q;
	logic [14:0] min_duty_q;
	logic [14:0] max_duty_q;
	logic [31:0] pwm_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_force_q  <= 16'd8192;
			min_duty_q   <= 15'd1280;
			max_duty_q   <= 15'd2048;
			pwm_period_q <= 32'd80000;
		end else if (cfg_we) begin
			case (cfg_index)
				fvmp_pkg::REG_MAX_FORCE:  max_force_q  <= cfg_data[15:0];
				fvmp_pkg::REG_MIN_DUTY:   min_duty_q   <= cfg_data[14:0];
				fvmp_pkg::REG_MAX_DUTY:   max_duty_q   <= cfg_data[14:0];
				fvmp_pkg::REG_PWM_PERIOD: pwm_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or being emptied.
	logic out_valid_q;
	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: angle difference and fold into the right half plane.
	logic [15:0]          d16;
	logic [31:0]          ang32;
	logic signed [32:0]   z0;
	fvmp_pkg::cordic_st_t st_c;
	fvmp_pkg::cordic_st_t st_s1;
	logic                 v_s1;

	always_comb begin
		d16   = 16'(in_ch.heading - in_ch.force_angle);
		ang32 = {d16, 16'd0} & fvmp_pkg::ANG_KEEP;
		z0    = 33'($signed(ang32));
		st_c.x    = fvmp_pkg::CORDIC_GAIN;
		st_c.y    = '0;
		st_c.mag  = in_ch.force_magnitude;
		st_c.flip = 1'b0;
		st_c.z    = z0;
		if (z0 > fvmp_pkg::QUARTER_TURN) begin
			st_c.z    = z0 - fvmp_pkg::HALF_TURN;
			st_c.flip = 1'b1;
		end else if (z0 < -fvmp_pkg::QUARTER_TURN) begin
			st_c.z    = z0 + fvmp_pkg::HALF_TURN;
			st_c.flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) st_s1 <= st_c;
	end

	// Rotation pipeline.
	fvmp_pkg::cordic_out_t cres;

	fvmp_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_st    (st_s1),
		.res      (cres)
	);

	// Stage 2: force times cosine and sine.
	logic signed [51:0] pc_s2;
	logic signed [51:0] ps_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s2 <= 52'($signed({1'b0, cres.mag}) * cres.cos_v);
			ps_s2 <= 52'($signed({1'b0, cres.mag}) * cres.sin_v);
		end
	end

	// Stage 3: round to Q4.12 and scale by half root two.
	logic signed [51:0] xt;
	logic signed [51:0] yt;
	logic signed [21:0] xr;
	logic signed [21:0] yr;
	logic signed [52:0] xs_s3;
	logic signed [52:0] ys_s3;
	logic               v_s3;

	always_comb begin
		xt = pc_s2 + 52'sd536870912;
		yt = -ps_s2 + 52'sd536870912;
		xr = xt[51:30];
		yr = yt[51:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s3 <= 53'(xr * $signed({1'b0, fvmp_pkg::HALF_SQRT2}));
			ys_s3 <= 53'(yr * $signed({1'b0, fvmp_pkg::HALF_SQRT2}));
		end
	end

	// Stage 4: round, clamp, split onto the motors and balance diagonal torque.
	logic signed [52:0] xv_t;
	logic signed [52:0] yv_t;
	logic signed [22:0] xv;
	logic signed [22:0] yv;
	logic signed [22:0] hl;
	logic signed [23:0] xp;
	logic signed [23:0] xn;
	logic signed [23:0] yp;
	logic signed [23:0] yn;
	logic signed [24:0] mm [0:3];
	logic signed [24:0] tq;
	logic signed [24:0] half_t;
	logic [16:0]        m_s4 [0:3];
	logic               v_s4;

	always_comb begin
		xv_t = xs_s3 + 53'sd536870912;
		yv_t = ys_s3 + 53'sd536870912;
		xv   = xv_t[52:30];
		yv   = yv_t[52:30];
		hl   = $signed({8'd0, max_force_q[15:1]});
		if (xv > hl) xv = hl;
		if (xv < -hl) xv = -hl;
		if (yv > hl) yv = hl;
		if (yv < -hl) yv = -hl;
		xp = (xv > 0) ? 24'(xv) : 24'sd0;
		xn = (xv > 0) ? 24'sd0 : -24'(xv);
		yp = (yv > 0) ? 24'(yv) : 24'sd0;
		yn = (yv > 0) ? 24'sd0 : -24'(yv);
		mm[0] = 25'(xp) + 25'(yp);
		mm[1] = 25'(xn) + 25'(yp);
		mm[2] = 25'(xp) + 25'(yn);
		mm[3] = 25'(xn) + 25'(yn);
		tq     = mm[0] + mm[3] - mm[1] - mm[2];
		half_t = (tq > 0) ? (tq >>> 1) : ((-tq) >>> 1);
		if (tq > 0) begin
			mm[1] = mm[1] + half_t;
			mm[2] = mm[2] + half_t;
		end else if (tq < 0) begin
			mm[0] = mm[0] + half_t;
			mm[3] = mm[3] + half_t;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) m_s4[l] <= mm[l][16:0];
		end
	end

	// Stage 5: motor force times duty span magnitude.
	logic signed [15:0] span;
	logic [15:0]        span_abs;
	logic [fvmp_pkg::DIV_BITS-1:0] n_s5 [0:3];
	logic               v_s5;

	always_comb begin
		span     = $signed({1'b0, max_duty_q}) - $signed({1'b0, min_duty_q});
		span_abs = span[15] ? 16'(-span) : 16'(span);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				n_s5[l] <= fvmp_pkg::DIV_BITS'(m_s4[l] * span_abs);
			end
		end
	end

	// Division by full-scale force.
	logic                          div_v;
	logic [fvmp_pkg::DIV_BITS-1:0] div_q [0:3];

	fvmp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (n_s5),
		.den       (max_force_q),
		.out_valid (div_v),
		.quo       (div_q)
	);

	// Stage 6: duty percent with the range clamp; the lower bound wins.
	logic signed [33:0] term [0:3];
	logic signed [33:0] duty [0:3];
	logic [14:0]        duty_s6 [0:3];
	logic               v_s6;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			term[l] = $signed({3'd0, div_q[l]});
			if (span[15]) term[l] = -term[l];
			if (max_force_q == 16'd0) term[l] = '0;
			duty[l] = $signed({19'd0, min_duty_q}) + term[l];
			if (duty[l] > $signed({19'd0, max_duty_q})) duty[l] = $signed({19'd0, max_duty_q});
			if (duty[l] < $signed({19'd0, min_duty_q})) duty[l] = $signed({19'd0, min_duty_q});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) duty_s6[l] <= duty[l][14:0];
		end
	end

	// Stage 7: period times duty, divided by 256 by dropping the low byte.
	logic [46:0]                   prod [0:3];
	logic [fvmp_pkg::PCT_BITS-1:0] pn_s7 [0:3];
	logic                          v_s7;

	always_comb begin
		for (int l = 0; l < 4; l++) prod[l] = 47'(pwm_period_q * duty_s6[l]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) pn_s7[l] <= prod[l][46:8];
		end
	end

	// Stage 8: division by one hundred starts. Two low bits are dropped and the rest
	// is multiplied by the scaled reciprocal of twenty-five in four partial products.
	logic [63:0] p00_s8 [0:3];
	logic [37:0] p01_s8 [0:3];
	logic [36:0] p10_s8 [0:3];
	logic [10:0] p11_s8 [0:3];
	logic        v_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				p00_s8[l] <= 64'(pn_s7[l][33:2] * fvmp_pkg::RECIP_LO);
				p01_s8[l] <= 38'(pn_s7[l][33:2] * fvmp_pkg::RECIP_HI);
				p10_s8[l] <= 37'(pn_s7[l][38:34] * fvmp_pkg::RECIP_LO);
				p11_s8[l] <= 11'(pn_s7[l][38:34] * fvmp_pkg::RECIP_HI);
			end
		end
	end

	// Stage 9: sum the partial products from bit 32 up; the quotient sits at bit 10.
	logic [43:0] hi_s9 [0:3];
	logic        v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				hi_s9[l] <= {12'd0, p00_s8[l][63:32]} + {6'd0, p01_s8[l]}
					+ {7'd0, p10_s8[l]} + {1'b0, p11_s8[l], 32'd0};
			end
		end
	end

	// Output register with saturation to 32 bits.
	logic [31:0] cmp_q [0:3];
	logic [31:0] sat [0:3];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (|hi_s9[l][43:42]) sat[l] = '1;
			else sat[l] = hi_s9[l][41:10];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) cmp_q[l] <= sat[l];
		end
	end

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_ch.valid;
			v_s2        <= cres.valid;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= div_v;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.compare_one   = cmp_q[0];
	assign out_ch.compare_two   = cmp_q[1];
	assign out_ch.compare_three = cmp_q[2];
	assign out_ch.compare_four  = cmp_q[3];

	// A finished division by one hundred always lands in the output register.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s9 |=> out_valid_q)
		else $error("finished request did not reach the output register");

	// A stall freezes the pipeline valid bits.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s7) && $stable(v_s4) && $stable(div_v))
		else $error("pipeline moved during an output stall");

	// The duty stage feeds the product stage in the next cycle when moving.
	a_duty_flow: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s6 |=> v_s7)
		else $error("duty request lost before the period product");

endmodule

`default_nettype wire

@@ sv/fvmp_cordic.sv @@
// Pipelined rotation unit: one CORDIC step per stage, gives sine and cosine.
`default_nettype none

module fvmp_cordic (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire fvmp_pkg::cordic_st_t in_st,
	output fvmp_pkg::cordic_out_t    res
);

	fvmp_pkg::cordic_st_t st_s [1:fvmp_pkg::CORDIC_STEPS];
	logic                 v_s  [1:fvmp_pkg::CORDIC_STEPS];

	for (genvar i = 0; i < fvmp_pkg::CORDIC_STEPS; i++) begin : g_step
		fvmp_pkg::cordic_st_t cur;
		fvmp_pkg::cordic_st_t nxt;
		logic                 cur_v;
		logic signed [34:0]   dx;
		logic signed [34:0]   dy;
		logic signed [32:0]   da;

		if (i == 0) begin : g_first
			assign cur   = in_st;
			assign cur_v = in_valid;
		end else begin : g_rest
			assign cur   = st_s[i];
			assign cur_v = v_s[i];
		end

		// One micro-rotation toward a zero residual angle.
		always_comb begin
			dx  = cur.y >>> i;
			dy  = cur.x >>> i;
			da  = $signed({1'b0, fvmp_pkg::ATAN_TAB[i]});
			nxt = cur;
			if (!cur.z[32]) begin
				nxt.x = cur.x - dx;
				nxt.y = cur.y + dy;
				nxt.z = cur.z - da;
			end else begin
				nxt.x = cur.x + dx;
				nxt.y = cur.y - dy;
				nxt.z = cur.z + da;
			end
		end

		always_ff @(posedge clk) begin
			if (en) st_s[i+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= cur_v;
		end
	end

	// Undo the half-turn fold.
	always_comb begin
		res.valid = v_s[fvmp_pkg::CORDIC_STEPS];
		res.mag   = st_s[fvmp_pkg::CORDIC_STEPS].mag;
		if (st_s[fvmp_pkg::CORDIC_STEPS].flip) begin
			res.cos_v = -st_s[fvmp_pkg::CORDIC_STEPS].x;
			res.sin_v = -st_s[fvmp_pkg::CORDIC_STEPS].y;
		end else begin
			res.cos_v = st_s[fvmp_pkg::CORDIC_STEPS].x;
			res.sin_v = st_s[fvmp_pkg::CORDIC_STEPS].y;
		end
	end

endmodule

`default_nettype wire

@@ sv/fvmp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, four lanes, shared divisor.
`default_nettype none

module fvmp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [fvmp_pkg::DIV_BITS-1:0] num [0:3],
	input  wire logic [15:0]                   den,
	output logic                               out_valid,
	output logic [fvmp_pkg::DIV_BITS-1:0]      quo [0:3]
);

	fvmp_pkg::div_lane_t ln_s [1:fvmp_pkg::DIV_BITS][0:3];
	logic                v_s  [1:fvmp_pkg::DIV_BITS];

	for (genvar i = 0; i < fvmp_pkg::DIV_BITS; i++) begin : g_bit
		logic cur_v;

		if (i == 0) begin : g_first
			assign cur_v = in_valid;
		end else begin : g_rest
			assign cur_v = v_s[i];
		end

		for (genvar l = 0; l < 4; l++) begin : g_lane
			fvmp_pkg::div_lane_t cur;
			fvmp_pkg::div_lane_t nxt;
			logic [16:0]         trial;
			logic                ge;

			if (i == 0) begin : g_first
				assign cur.rem  = 16'd0;
				assign cur.work = num[l];
			end else begin : g_rest
				assign cur = ln_s[i][l];
			end

			// Shift in the next dividend bit and subtract when it fits.
			always_comb begin
				trial    = {cur.rem, cur.work[fvmp_pkg::DIV_BITS-1]};
				ge       = trial >= {1'b0, den};
				nxt.rem  = ge ? 16'(trial - {1'b0, den}) : trial[15:0];
				nxt.work = {cur.work[fvmp_pkg::DIV_BITS-2:0], ge};
			end

			always_ff @(posedge clk) begin
				if (en) ln_s[i+1][l] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= cur_v;
		end
	end

	assign out_valid = v_s[fvmp_pkg::DIV_BITS];
	for (genvar l = 0; l < 4; l++) begin : g_out
		assign quo[l] = ln_s[fvmp_pkg::DIV_BITS][l].work;
	end

endmodule

`default_nettype wire
